/* hdl/ook_pulse_frame_receiver_assert.svh */
// assertion macros shared by the receiver rtl
`ifndef OOK_PULSE_FRAME_RECEIVER_ASSERT_SVH
`define OOK_PULSE_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define OPF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define OPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/opfr_pkg.sv */
package opfr_pkg;

   // field widths
   localparam int DUR_W   = 20;
   localparam int LEN_W   = 6;
   localparam int PAIR_W  = 7;
   localparam int INDEX_W = 3;

   // frame capacity in bits and in pairs
   localparam int MAX_BITS = 200;
   localparam int PAIR_CAP = MAX_BITS / 2;

   // register reset values
   localparam logic [DUR_W-1:0] PREAMBLE_MIN_RST  = DUR_W'(400);
   localparam logic [DUR_W-1:0] PREAMBLE_MAX_RST  = DUR_W'(540);
   localparam logic [DUR_W-1:0] SYNC_MIN_RST      = DUR_W'(880);
   localparam logic [DUR_W-1:0] SYNC_MAX_RST      = DUR_W'(1020);
   localparam logic [DUR_W-1:0] BIT_THRESHOLD_RST = DUR_W'(800);
   localparam logic [LEN_W-1:0] PREAMBLE_LEN_RST  = LEN_W'(23);
   localparam logic [DUR_W-1:0] END_GAP_RST       = DUR_W'(10000);

   // register indexes
   typedef enum logic [INDEX_W-1:0] {
      REG_PREAMBLE_MIN  = 3'd0,
      REG_PREAMBLE_MAX  = 3'd1,
      REG_SYNC_MIN      = 3'd2,
      REG_SYNC_MAX      = 3'd3,
      REG_BIT_THRESHOLD = 3'd4,
      REG_PREAMBLE_LEN  = 3'd5,
      REG_END_GAP       = 3'd6
   } reg_index_type;

   // result kinds
   localparam logic KIND_DATA       = 1'b0;
   localparam logic KIND_SYNC_ERROR = 1'b1;

   // receiver phase, one-hot
   typedef enum logic [3:0] {
      PH_HUNT  = 4'b0001,
      PH_SYNC1 = 4'b0010,
      PH_SYNC2 = 4'b0100,
      PH_DATA  = 4'b1000
   } phase_type;

endpackage

/* hdl/ook_pulse_frame_receiver.sv */
// On-off keyed pulse frame receiver. Each input beat is one measured pulse (low width and
// the high gap before it, in microseconds). The block hunts for a run of in-window
// preamble pulses, checks two sync pulses, then emits one result beat per data pulse
// carrying two bits, the pair index and last/overflow flags; a failed sync gives one
// sync-error beat. Hunt pulses and passing sync pulses give no beat. One pulse is accepted
// every clock cycle unless the result side stalls; a pulse passes through one input register
// and one result register before its result is presented. A stall on the result side
// holds back only a pending pulse that produces a result. A frame holds at most 100 pairs.
// Registers are written through the csr port while no pulse is in flight.
module ook_pulse_frame_receiver
   import opfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [DUR_W-1:0]    req_low_us,
   input  logic [DUR_W-1:0]    req_high_us,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic                rsp_high_bit,
   output logic                rsp_low_bit,
   output logic [PAIR_W-1:0]   rsp_pair_index,
   output logic                rsp_last,
   output logic                rsp_overflow,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [DUR_W-1:0]    csr_data
);

   // configuration registers
   logic [DUR_W-1:0] preamble_min_ff;
   logic [DUR_W-1:0] preamble_max_ff;
   logic [DUR_W-1:0] sync_min_ff;
   logic [DUR_W-1:0] sync_max_ff;
   logic [DUR_W-1:0] bit_threshold_ff;
   logic [LEN_W-1:0] preamble_len_ff;
   logic [DUR_W-1:0] end_gap_ff;

   // input register
   logic             in_valid_ff;
   logic             in_valid_in;
   logic [DUR_W-1:0] in_low_ff;
   logic [DUR_W-1:0] in_high_ff;

   // receiver state
   phase_type         phase_ff;
   phase_type         phase_in;
   logic [LEN_W-1:0]  run_ff;
   logic [LEN_W-1:0]  run_in;
   logic              sync_seen_ff;
   logic              sync_seen_in;
   logic [PAIR_W-1:0] pair_count_ff;
   logic [PAIR_W-1:0] pair_count_in;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_kind_ff;
   logic              rsp_high_bit_ff;
   logic              rsp_low_bit_ff;
   logic [PAIR_W-1:0] rsp_pair_index_ff;
   logic              rsp_last_ff;
   logic              rsp_overflow_ff;

   // step results
   logic              produce;
   logic              res_kind;
   logic              res_high_bit;
   logic              res_low_bit;
   logic [PAIR_W-1:0] res_pair_index;
   logic              res_last;
   logic              res_overflow;

   // handshake
   logic req_take;
   logic out_free;
   logic advance;

   // window compares and counters
   logic              in_preamble;
   logic              in_sync;
   logic [LEN_W-1:0]  run_inc;
   logic [LEN_W-1:0]  need;
   logic              gap_end;
   logic              full;
   logic [PAIR_W:0]   pair_next;

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!produce || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !in_valid_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_min_ff  <= PREAMBLE_MIN_RST;
         preamble_max_ff  <= PREAMBLE_MAX_RST;
         sync_min_ff      <= SYNC_MIN_RST;
         sync_max_ff      <= SYNC_MAX_RST;
         bit_threshold_ff <= BIT_THRESHOLD_RST;
         preamble_len_ff  <= PREAMBLE_LEN_RST;
         end_gap_ff       <= END_GAP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PREAMBLE_MIN:  preamble_min_ff  <= csr_data;
            REG_PREAMBLE_MAX:  preamble_max_ff  <= csr_data;
            REG_SYNC_MIN:      sync_min_ff      <= csr_data;
            REG_SYNC_MAX:      sync_max_ff      <= csr_data;
            REG_BIT_THRESHOLD: bit_threshold_ff <= csr_data;
            REG_PREAMBLE_LEN:  preamble_len_ff  <= csr_data[LEN_W-1:0];
            REG_END_GAP:       end_gap_ff       <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register valid
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_low_ff  <= req_low_us;
         in_high_ff <= req_high_us;
      end
   end

   // window compares
   assign in_preamble = (in_low_ff > preamble_min_ff) && (in_low_ff < preamble_max_ff);
   assign in_sync     = (in_low_ff > sync_min_ff) && (in_low_ff < sync_max_ff);
   assign run_inc     = run_ff + LEN_W'(1);
   assign need        = (preamble_len_ff == '0) ? LEN_W'(1) : preamble_len_ff;
   assign gap_end     = in_low_ff >= end_gap_ff;
   assign pair_next   = {1'b0, pair_count_ff} + (PAIR_W+1)'(1);
   assign full        = pair_next >= (PAIR_W+1)'(PAIR_CAP);

   // one step of the receiver
   always_comb begin
      phase_in       = phase_ff;
      run_in         = run_ff;
      sync_seen_in   = sync_seen_ff;
      pair_count_in  = pair_count_ff;
      produce        = 1'b0;
      res_kind       = KIND_DATA;
      res_high_bit   = 1'b0;
      res_low_bit    = 1'b0;
      res_pair_index = '0;
      res_last       = 1'b0;
      res_overflow   = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (in_preamble) begin
               if (run_inc >= need || run_inc == '0) begin
                  phase_in     = PH_SYNC1;
                  run_in       = '0;
                  sync_seen_in = 1'b0;
               end else begin
                  run_in = run_inc;
               end
            end else begin
               run_in = '0;
            end
         end
         PH_SYNC1: begin
            sync_seen_in = in_sync;
            phase_in     = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (sync_seen_ff && in_sync) begin
               phase_in      = PH_DATA;
               pair_count_in = '0;
               sync_seen_in  = 1'b0;
            end else begin
               produce       = 1'b1;
               res_kind      = KIND_SYNC_ERROR;
               phase_in      = PH_HUNT;
               run_in        = '0;
               sync_seen_in  = 1'b0;
               pair_count_in = '0;
            end
         end
         PH_DATA: begin
            produce        = 1'b1;
            res_high_bit   = in_high_ff > bit_threshold_ff;
            res_low_bit    = in_low_ff > bit_threshold_ff;
            res_pair_index = pair_count_ff;
            res_last       = gap_end || full;
            res_overflow   = full && !gap_end;
            if (gap_end || full) begin
               phase_in      = PH_HUNT;
               run_in        = '0;
               sync_seen_in  = 1'b0;
               pair_count_in = '0;
            end else begin
               pair_count_in = pair_next[PAIR_W-1:0];
            end
         end
         default: begin
            phase_in      = PH_HUNT;
            run_in        = '0;
            sync_seen_in  = 1'b0;
            pair_count_in = '0;
         end
      endcase
   end

   // receiver state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         run_ff        <= '0;
         sync_seen_ff  <= 1'b0;
         pair_count_ff <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         run_ff        <= run_in;
         sync_seen_ff  <= sync_seen_in;
         pair_count_ff <= pair_count_in;
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_kind_ff       <= res_kind;
         rsp_high_bit_ff   <= res_high_bit;
         rsp_low_bit_ff    <= res_low_bit;
         rsp_pair_index_ff <= res_pair_index;
         rsp_last_ff       <= res_last;
         rsp_overflow_ff   <= res_overflow;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_high_bit   = rsp_high_bit_ff;
   assign rsp_low_bit    = rsp_low_bit_ff;
   assign rsp_pair_index = rsp_pair_index_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   // checks
`include "ook_pulse_frame_receiver_assert.svh"

   `OPF_ASSERT_NOW(a_sync_error_clean,
      rsp_valid_ff && rsp_kind_ff == KIND_SYNC_ERROR,
      !rsp_high_bit_ff && !rsp_low_bit_ff && rsp_pair_index_ff == '0 &&
      !rsp_last_ff && !rsp_overflow_ff,
      "sync error beat carries nonzero fields")
   `OPF_ASSERT_NOW(a_overflow_is_last, rsp_valid_ff && rsp_overflow_ff, rsp_last_ff,
      "overflow beat without last")
   `OPF_ASSERT_NOW(a_pair_in_range, rsp_valid_ff && rsp_kind_ff == KIND_DATA,
      rsp_pair_index_ff < PAIR_W'(PAIR_CAP), "pair index beyond frame capacity")
   `OPF_ASSERT_NEXT(a_last_returns_to_hunt, advance && produce && res_last,
      phase_ff == PH_HUNT && pair_count_ff == '0, "frame end did not return to hunt")
   `OPF_ASSERT_NOW(a_run_only_in_hunt, phase_ff != PH_HUNT, run_ff == '0,
      "preamble run left over outside hunt")

endmodule
